// ===== design/polygon_fan_hit_test_with_bounds_assert.svh =====
// Assertion macros used by the fan hit test top level.
`ifndef POLYGON_FAN_HIT_TEST_WITH_BOUNDS_ASSERT_SVH
`define POLYGON_FAN_HIT_TEST_WITH_BOUNDS_ASSERT_SVH
`define PFH_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("pfh check failed");
`define PFH_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("pfh check failed");
`endif

// ===== design/pfh_pkg.sv =====
// Package with types and constants of the fan hit test.
package pfh_pkg;
	localparam int MaxVertices = 256;
	localparam int IdxBits = 8;
	localparam int CntBits = 9;
	localparam logic [1:0] ModeClear = 2'd0;
	localparam logic [1:0] ModeAppend = 2'd1;
	localparam logic [1:0] ModeQuery = 2'd2;
	typedef enum logic [6:0] {
		StIdle = 7'b0000001,
		StRead = 7'b0000010,
		StDiff = 7'b0000100,
		StMulA = 7'b0001000,
		StMulB = 7'b0010000,
		StTest = 7'b0100000,
		StOut = 7'b1000000
	} state_t;
endpackage

// ===== design/pfh_tri.sv =====
// Triangle test unit: sign-aware barycentric test from registered cross products.
module pfh_tri (
	input logic signed [34:0] d,
	input logic signed [34:0] u,
	input logic signed [34:0] v,
	output logic hit
);
	logic signed [35:0] dd, uu, vv, sum;
	always_comb begin
		dd = d[34] ? -36'(d) : 36'(d);
		uu = d[34] ? -36'(u) : 36'(u);
		vv = d[34] ? -36'(v) : 36'(v);
		sum = uu + vv;
		hit = (d != '0) && !uu[35] && !vv[35] && (sum < dd);
	end
endmodule

// ===== design/polygon_fan_hit_test_with_bounds.sv =====
// Top level of the fan hit test with running bounding box.
// Channel | dir | fields
// s_axis  | in  | tuser: mode[1:0]; tdata: x[15:0], y[31:16]
// m_axis  | out | tdata: hit, store_full, empty_res, box_min_x, box_min_y, box_max_x, box_max_y
// cfg     | in  | data: bounds_margin[9:0]
// Clear, append, the unused mode and a query over fewer than three vertices go straight from idle to the output.
// A query takes each fan triangle through store reads of three vertices, a difference step, six products
// through the shared multiplier and a test; it stops at the first hit.
// Reset clears count, box and margin; the vertex store is not cleared.
// Input and configuration are not ready until the result has been taken.
module polygon_fan_hit_test_with_bounds (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [31:0] s_axis_tdata, // x, y
	input logic [1:0] s_axis_tuser, // mode
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [71:0] m_axis_tdata, // hit, store_full, empty_res, min_x, min_y, max_x, max_y
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [9:0] cfg_data // bounds_margin
);
	pfh_pkg::state_t state_q;
	logic [31:0] mem [pfh_pkg::MaxVertices];
	logic [31:0] rd_q;
	logic [1:0] mode_q;
	logic signed [15:0] px_q, py_q, ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic signed [15:0] lx_q, ly_q, gx_q, gy_q;
	logic [pfh_pkg::CntBits-1:0] cnt_q, i_q;
	logic [1:0] rs_q;
	logic [pfh_pkg::IdxBits-1:0] raddr;
	logic [pfh_pkg::CntBits-1:0] ridx;
	logic signed [16:0] v0x_q, v0y_q, v1x_q, v1y_q, v2x_q, v2y_q;
	logic signed [34:0] d_q, u_q, v_q, pa_q;
	logic [2:0] ms_q;
	logic signed [16:0] ma, mb;
	logic signed [33:0] prod;
	logic thit, hit_q, full_q;
	logic [9:0] marg_q;
	logic signed [15:0] xin, yin;
	logic [1:0] mode_in;
	logic signed [16:0] bminx, bminy, bmaxx, bmaxy;

	assign mode_in = s_axis_tuser;
	assign xin = s_axis_tdata[15:0];
	assign yin = s_axis_tdata[31:16];
	assign s_axis_tready = (state_q == pfh_pkg::StIdle);
	assign cfg_ready = (state_q == pfh_pkg::StIdle);
	assign m_axis_tvalid = (state_q == pfh_pkg::StOut);

	always_comb begin
		ridx = i_q + pfh_pkg::CntBits'(rs_q);
		if (ridx >= cnt_q) ridx = ridx - cnt_q;
		if (ridx >= cnt_q) ridx = ridx - cnt_q;
		raddr = ridx[pfh_pkg::IdxBits-1:0];
	end

	always_comb begin
		case (ms_q)
			3'd0: begin ma = v0x_q; mb = v1y_q; end
			3'd1: begin ma = v0y_q; mb = v1x_q; end
			3'd2: begin ma = v2x_q; mb = v1y_q; end
			3'd3: begin ma = v2y_q; mb = v1x_q; end
			3'd4: begin ma = v0x_q; mb = v2y_q; end
			3'd5: begin ma = v0y_q; mb = v2x_q; end
			default: begin ma = v0x_q; mb = v1y_q; end
		endcase
	end
	assign prod = ma * mb;

	pfh_tri u_tri (.d(d_q), .u(u_q), .v(v_q), .hit(thit));

	always_ff @(posedge clk) begin
		if (state_q == pfh_pkg::StIdle && s_axis_tvalid && mode_in == pfh_pkg::ModeAppend
				&& cnt_q < pfh_pkg::CntBits'(pfh_pkg::MaxVertices))
			mem[cnt_q[pfh_pkg::IdxBits-1:0]] <= {yin, xin};
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfh_pkg::StIdle;
			cnt_q <= '0;
			lx_q <= '0; ly_q <= '0; gx_q <= '0; gy_q <= '0;
			marg_q <= '0;
			hit_q <= 1'b0; full_q <= 1'b0;
			mode_q <= '0; i_q <= '0; rs_q <= '0; ms_q <= '0;
		end else begin
			case (state_q)
				pfh_pkg::StIdle: begin
					if (cfg_valid) marg_q <= cfg_data;
					if (s_axis_tvalid) begin
						mode_q <= mode_in;
						px_q <= xin; py_q <= yin;
						hit_q <= 1'b0; full_q <= 1'b0;
						i_q <= '0; rs_q <= '0;
						state_q <= pfh_pkg::StOut;
						case (mode_in)
							pfh_pkg::ModeClear: begin
								cnt_q <= '0;
								lx_q <= '0; ly_q <= '0; gx_q <= '0; gy_q <= '0;
							end
							pfh_pkg::ModeAppend: begin
								if (cnt_q >= pfh_pkg::CntBits'(pfh_pkg::MaxVertices))
									full_q <= 1'b1;
								else begin
									cnt_q <= cnt_q + 1'b1;
									if (cnt_q == '0) begin
										lx_q <= xin; gx_q <= xin; ly_q <= yin; gy_q <= yin;
									end else begin
										if (xin < lx_q) lx_q <= xin;
										if (xin > gx_q) gx_q <= xin;
										if (yin < ly_q) ly_q <= yin;
										if (yin > gy_q) gy_q <= yin;
									end
								end
							end
							pfh_pkg::ModeQuery: begin
								if (cnt_q >= 9'd3) state_q <= pfh_pkg::StRead;
							end
							default: ;
						endcase
					end
				end
				pfh_pkg::StRead: begin
					// Reads of a, b, c land in the cycle after each address.
					if (rs_q == 2'd1) begin ax_q <= rd_q[15:0]; ay_q <= rd_q[31:16]; end
					if (rs_q == 2'd2) begin bx_q <= rd_q[15:0]; by_q <= rd_q[31:16]; end
					if (rs_q == 2'd3) begin
						cx_q <= rd_q[15:0]; cy_q <= rd_q[31:16];
						state_q <= pfh_pkg::StDiff;
					end
					rs_q <= rs_q + 1'b1;
				end
				pfh_pkg::StDiff: begin
					v0x_q <= 17'(cx_q) - 17'(ax_q); v0y_q <= 17'(cy_q) - 17'(ay_q);
					v1x_q <= 17'(bx_q) - 17'(ax_q); v1y_q <= 17'(by_q) - 17'(ay_q);
					v2x_q <= 17'(px_q) - 17'(ax_q); v2y_q <= 17'(py_q) - 17'(ay_q);
					ms_q <= '0;
					state_q <= pfh_pkg::StMulA;
				end
				pfh_pkg::StMulA: begin
					pa_q <= 35'(prod);
					ms_q <= ms_q + 1'b1;
					state_q <= pfh_pkg::StMulB;
				end
				pfh_pkg::StMulB: begin
					case (ms_q)
						3'd1: d_q <= pa_q - 35'(prod);
						3'd3: u_q <= pa_q - 35'(prod);
						3'd5: v_q <= pa_q - 35'(prod);
						default: ;
					endcase
					ms_q <= ms_q + 1'b1;
					state_q <= (ms_q == 3'd5) ? pfh_pkg::StTest : pfh_pkg::StMulA;
				end
				pfh_pkg::StTest: begin
					ms_q <= '0;
					state_q <= pfh_pkg::StOut;
					if (thit) hit_q <= 1'b1;
					else if (i_q + 1'b1 < cnt_q) begin
						i_q <= i_q + 1'b1;
						rs_q <= '0;
						state_q <= pfh_pkg::StRead;
					end
				end
				pfh_pkg::StOut: begin
					if (m_axis_tready) state_q <= pfh_pkg::StIdle;
				end
				default: state_q <= pfh_pkg::StIdle;
			endcase
		end
	end

	always_comb begin
		bminx = 17'(lx_q) - 17'(marg_q);
		bminy = 17'(ly_q) - 17'(marg_q);
		bmaxx = 17'(gx_q) + 17'(marg_q);
		bmaxy = 17'(gy_q) + 17'(marg_q);
		if (cnt_q == '0) begin
			bminx = '0; bminy = '0; bmaxx = '0; bmaxy = '0;
		end
		m_axis_tdata = {1'b0, bmaxy, bmaxx, bminy, bminx, (cnt_q == '0), full_q, hit_q};
	end

`include "polygon_fan_hit_test_with_bounds_assert.svh"
	`PFH_ASSERT_IMP(a_ready_idle, s_axis_tready, !m_axis_tvalid)
	`PFH_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= 9'(pfh_pkg::MaxVertices))
	`PFH_ASSERT_IMP(a_hit_query, m_axis_tvalid && hit_q, mode_q == pfh_pkg::ModeQuery)
	`PFH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

// ===== tb/polygon_fan_hit_test_with_bounds_tb.sv =====
// Testbench for the polygon fan hit test: directed table, then random polygons with a predictor.
`timescale 1ns / 1ps

module polygon_fan_hit_test_with_bounds_tb;
	localparam logic [1:0] ModeIgnored = 2'd3;
	localparam int StallLimit = 20000;

	typedef struct packed {
		logic hit;
		logic full;
		logic empty;
		logic [16:0] min_x;
		logic [16:0] min_y;
		logic [16:0] max_x;
		logic [16:0] max_y;
	} fan_result_t;

	typedef struct {
		logic [1:0] md;
		int px;
		int py;
		bit typed;
		fan_result_t res;
	} table_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [71:0] m_axis_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [9:0] cfg_data = '0;

	polygon_fan_hit_test_with_bounds dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predicted state of the block.
	int vx[pfh_pkg::MaxVertices];
	int vy[pfh_pkg::MaxVertices];
	int n_vert = 0;
	int lo_x = 0, lo_y = 0, hi_x = 0, hi_y = 0;
	int margin = 0;

	fan_result_t pending_results[$];
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int mismatches = 0;
	int stall_cycles = 0;

	function automatic bit triangle_hit(int ia, int ib, int ic, int px, int py);
		longint v0x, v0y, v1x, v1y, v2x, v2y, d, u, v;
		v0x = vx[ic] - vx[ia];
		v0y = vy[ic] - vy[ia];
		v1x = vx[ib] - vx[ia];
		v1y = vy[ib] - vy[ia];
		v2x = px - vx[ia];
		v2y = py - vy[ia];
		d = v0x * v1y - v0y * v1x;
		u = v2x * v1y - v2y * v1x;
		v = v0x * v2y - v0y * v2x;
		if (d == 0)
			return 0;
		if (d < 0) begin
			d = -d;
			u = -u;
			v = -v;
		end
		return u >= 0 && v >= 0 && (u + v) < d;
	endfunction

	function automatic fan_result_t fan_step(logic [1:0] md, int px, int py);
		fan_result_t r;
		r.hit = 0;
		r.full = 0;
		if (md == pfh_pkg::ModeClear) begin
			n_vert = 0;
			lo_x = 0;
			lo_y = 0;
			hi_x = 0;
			hi_y = 0;
		end else if (md == pfh_pkg::ModeAppend) begin
			if (n_vert >= pfh_pkg::MaxVertices) begin
				r.full = 1;
			end else begin
				if (n_vert == 0) begin
					lo_x = px;
					hi_x = px;
					lo_y = py;
					hi_y = py;
				end else begin
					if (px < lo_x) lo_x = px;
					if (px > hi_x) hi_x = px;
					if (py < lo_y) lo_y = py;
					if (py > hi_y) hi_y = py;
				end
				vx[n_vert] = px;
				vy[n_vert] = py;
				n_vert++;
			end
		end else if (md == pfh_pkg::ModeQuery) begin
			for (int i = 0; i < n_vert; i++)
				if (triangle_hit(i, (i + 1) % n_vert, (i + 2) % n_vert, px, py))
					r.hit = 1;
		end
		r.empty = (n_vert == 0);
		if (n_vert == 0) begin
			r.min_x = '0;
			r.min_y = '0;
			r.max_x = '0;
			r.max_y = '0;
		end else begin
			r.min_x = 17'(lo_x - margin);
			r.min_y = 17'(lo_y - margin);
			r.max_x = 17'(hi_x + margin);
			r.max_y = 17'(hi_y + margin);
		end
		return r;
	endfunction

	task automatic send_item(logic [1:0] md, int px, int py, bit typed = 0,
			fan_result_t typed_res = '{default: '0});
		fan_result_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {16'(py), 16'(px)};
		s_axis_tuser <= md;
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = fan_step(md, px, py);
		if (typed)
			r = typed_res;
		pending_results = {pending_results, r};
	endtask

	task automatic drain;
		s_axis_tvalid <= 0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_margin(int value);
		drain();
		repeat (8) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= 10'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		margin = value;
		cfg_valid <= 0;
	endtask

	always @(posedge clk) begin
		fan_result_t e, a;
		if (m_axis_tvalid && m_axis_tready) begin
			a.hit = m_axis_tdata[0];
			a.full = m_axis_tdata[1];
			a.empty = m_axis_tdata[2];
			a.min_x = m_axis_tdata[19:3];
			a.min_y = m_axis_tdata[36:20];
			a.max_x = m_axis_tdata[53:37];
			a.max_y = m_axis_tdata[70:54];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item: %p", a);
			end else begin
				e = pending_results.pop_front();
				if (a != e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, got %p", e, a);
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("polygon_fan_hit_test_with_bounds_tb NOT OK");
			$finish;
		end
	end

	function automatic int pick_coord(int c, int spread);
		int v;
		v = c + $urandom_range(2 * spread) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	// One random polygon followed by queries around its box, some queries anywhere, extra appends and ignored items.
	task automatic random_polygon;
		int k, q, spread, cx, cy;
		if ($urandom_range(99) < 80 || n_vert > 40)
			send_item(pfh_pkg::ModeClear, $urandom_range(65535) - 32768,
				$urandom_range(65535) - 32768);
		spread = ($urandom_range(3) == 0) ? 32768 : (1 << $urandom_range(2, 13));
		cx = ($urandom_range(3) == 0) ? 0 : $urandom_range(32767) - 16384;
		cy = ($urandom_range(3) == 0) ? 0 : $urandom_range(32767) - 16384;
		k = $urandom_range(7);
		for (int i = 0; i < k; i++)
			send_item(pfh_pkg::ModeAppend, pick_coord(cx, spread), pick_coord(cy, spread));
		q = $urandom_range(1, 6);
		for (int i = 0; i < q; i++) begin
			case ($urandom_range(19))
				0: send_item(ModeIgnored, $urandom_range(65535) - 32768,
					$urandom_range(65535) - 32768);
				1: send_item(pfh_pkg::ModeQuery, $urandom_range(65535) - 32768,
					$urandom_range(65535) - 32768);
				2: send_item(pfh_pkg::ModeAppend, pick_coord(cx, spread),
					pick_coord(cy, spread));
				default: send_item(pfh_pkg::ModeQuery, pick_coord(cx, spread),
					pick_coord(cy, spread));
			endcase
		end
	endtask

	table_row_t directed[] = '{
		'{pfh_pkg::ModeQuery, 0, 0, 1, '{0, 0, 1, 0, 0, 0, 0}},
		'{ModeIgnored, -1, -1, 1, '{0, 0, 1, 0, 0, 0, 0}},
		'{pfh_pkg::ModeAppend, -32768, 32767, 1,
			'{0, 0, 0, -17'sd32768, 17'sd32767, -17'sd32768, 17'sd32767}},
		'{pfh_pkg::ModeAppend, 32767, -32768, 1,
			'{0, 0, 0, -17'sd32768, -17'sd32768, 17'sd32767, 17'sd32767}},
		'{pfh_pkg::ModeQuery, 0, 0, 1,
			'{0, 0, 0, -17'sd32768, -17'sd32768, 17'sd32767, 17'sd32767}},
		'{pfh_pkg::ModeAppend, 0, -1, 1,
			'{0, 0, 0, -17'sd32768, -17'sd32768, 17'sd32767, 17'sd32767}},
		'{pfh_pkg::ModeQuery, 0, -1, 1,
			'{0, 0, 0, -17'sd32768, -17'sd32768, 17'sd32767, 17'sd32767}},
		'{pfh_pkg::ModeClear, 32767, 32767, 1, '{0, 0, 1, 0, 0, 0, 0}},
		'{pfh_pkg::ModeAppend, 0, 0, 0, '{default: '0}},
		'{pfh_pkg::ModeAppend, 100, 0, 0, '{default: '0}},
		'{pfh_pkg::ModeAppend, 0, 100, 0, '{default: '0}},
		'{pfh_pkg::ModeQuery, 10, 10, 0, '{default: '0}},
		'{pfh_pkg::ModeQuery, 100, 0, 0, '{default: '0}},
		'{pfh_pkg::ModeQuery, 50, 50, 0, '{default: '0}},
		'{pfh_pkg::ModeQuery, -1, 5, 0, '{default: '0}},
		'{ModeIgnored, 7, 7, 0, '{default: '0}},
		'{pfh_pkg::ModeQuery, -32768, -32768, 0, '{default: '0}},
		'{pfh_pkg::ModeAppend, -100, -100, 0, '{default: '0}},
		'{pfh_pkg::ModeQuery, -10, -10, 0, '{default: '0}},
		'{pfh_pkg::ModeQuery, 32767, 32767, 0, '{default: '0}}
	};

	initial begin
		int sent;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i])
			send_item(directed[i].md, directed[i].px, directed[i].py,
				directed[i].typed, directed[i].res);
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 86 : 0;
			rx_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 29 : 0;
			write_margin(phase == 0 ? 1023 : phase == 1 ? $urandom_range(1, 1022) : 0);
			sent = 0;
			while (sent < 260) begin
				random_polygon();
				sent += 8;
				if ($urandom_range(19) == 0)
					drain();
			end
			if (phase == 2) begin
				write_margin($urandom_range(1023));
				send_item(pfh_pkg::ModeClear, 0, 0);
				for (int i = 0; i < pfh_pkg::MaxVertices + 2; i++)
					send_item(pfh_pkg::ModeAppend, $urandom_range(65535) - 32768,
						$urandom_range(65535) - 32768);
				send_item(pfh_pkg::ModeQuery, $urandom_range(2000) - 1000,
					$urandom_range(2000) - 1000);
				send_item(pfh_pkg::ModeQuery, $urandom_range(65535) - 32768,
					$urandom_range(65535) - 32768);
				send_item(pfh_pkg::ModeClear, 0, 0);
			end
		end
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("polygon_fan_hit_test_with_bounds_tb OK");
		else
			$display("polygon_fan_hit_test_with_bounds_tb NOT OK");
		$finish;
	end
endmodule
